// ===== hw/rtl/pmt_pkg.sv =====
`timescale 1ns / 1ps

package pmt_pkg;

  // Width of a stored page frame.
  localparam int unsigned FrameW = 20;

  // Command codes of the input word.
  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // Status codes of the result word.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_ALREADY   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Hardware TLB action reported with each result.
  typedef enum logic [1:0] {
    TLB_NONE  = 2'd0,
    TLB_WRITE = 2'd1,
    TLB_INVAL = 2'd2
  } tlb_e;

endpackage

// ===== hw/rtl/pmt_frame_ram.sv =====
`timescale 1ns / 1ps

// Single-port-write, single-port-read RAM with a registered read.
module pmt_frame_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 40,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/page_mapping_table.sv =====
`timescale 1ns / 1ps

// Fully associative page mapping table.
//
// Command channel: a word (cmd_i, virt_addr_i, phys_addr_i) is taken at a rising
// edge where start is high and busy is low. Frames are the addresses shifted
// right by PAGE_SHIFT, kept to 20 bits. Commands are map, lookup and remove.
//
// Result channel: done_o is high for exactly one cycle and qualifies status_o,
// phys_frame_o and tlb_update_o. The receiver cannot stall; the word is
// taken at the edge that ends that cycle.
//
// Timing: each command reads every slot of the frame RAM once, one slot a
// cycle through its single read port, then passes through S_LAST and
// S_FINISH while busy stays high; done_o follows in the cycle busy drops.
// The next word can be started in that same cycle. One command is in flight
// at a time.
//
// Reset clears all valid marks and the control state; the frame RAM is not
// cleared, since only entries with a valid mark are ever used.
module page_mapping_table #(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [pmt_pkg::FrameW-1:0] phys_frame_o,
  output logic [1:0]  tlb_update_o
);

  localparam int unsigned FW   = pmt_pkg::FrameW;
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [1:0]       cmd_q;
  logic [FW-1:0]    vf_q, pf_q;
  logic [IdxW-1:0]  idx_q;
  logic             cmp_en_q;
  logic [IdxW-1:0]  cmp_idx_q;
  logic             hit_q, dup_q, empty_q;
  logic [IdxW-1:0]  hit_idx_q, empty_idx_q;
  logic [FW-1:0]    hit_pf_q;
  logic [SLOTS-1:0] valid_q;

  logic [31:0]      vshift, pshift;
  logic [2*FW-1:0]  rd_data;
  logic [FW-1:0]    rd_vf, rd_pf;
  logic             rd_valid, vf_match, pf_match;
  logic             accept;
  logic             do_write, do_clear;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Frame extraction from the incoming addresses.
  assign vshift = virt_addr_i >> PAGE_SHIFT;
  assign pshift = phys_addr_i >> PAGE_SHIFT;

  // Decode the slot that came back from the RAM.
  assign rd_vf    = rd_data[2*FW-1:FW];
  assign rd_pf    = rd_data[FW-1:0];
  assign rd_valid = valid_q[cmp_idx_q];
  assign vf_match = (rd_vf == vf_q);
  assign pf_match = (rd_pf == pf_q);

  // Updates made at the end of a command.
  assign do_write = (state_q == S_FINISH) && (cmd_q == pmt_pkg::CMD_MAP) &&
                    !dup_q && empty_q;
  assign do_clear = (state_q == S_FINISH) && (cmd_q == pmt_pkg::CMD_REMOVE) && hit_q;

  pmt_frame_ram #(
    .Depth (SLOTS),
    .Width (2 * FW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (empty_idx_q),
    .wdata_i ({vf_q, pf_q}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // Valid marks, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_write) begin
      valid_q[empty_idx_q] <= 1'b1;
    end else if (do_clear) begin
      valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // Command word, held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      vf_q  <= vshift[FW-1:0];
      pf_q  <= pshift[FW-1:0];
    end
  end

  // Sequencer: scan the slots, then finish and register the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cmp_en_q     <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      dup_q        <= 1'b0;
      empty_q      <= 1'b0;
      hit_idx_q    <= '0;
      empty_idx_q  <= '0;
      hit_pf_q     <= '0;
      done_o       <= 1'b0;
      status_o     <= pmt_pkg::ST_NOT_FOUND;
      phys_frame_o <= '0;
      tlb_update_o <= pmt_pkg::TLB_NONE;
    end else begin
      done_o    <= 1'b0;
      cmp_en_q  <= (state_q == S_SCAN);
      cmp_idx_q <= idx_q;

      // Compare the slot read in the previous cycle.
      if (cmp_en_q) begin
        if (!rd_valid) begin
          empty_q     <= 1'b1;
          empty_idx_q <= cmp_idx_q;
        end else begin
          if (vf_match && pf_match) begin
            dup_q <= 1'b1;
          end
          if (vf_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
            hit_pf_q  <= rd_pf;
          end
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            dup_q   <= 1'b0;
            empty_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (idx_q == LastIdx) begin
            state_q <= S_LAST;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_LAST: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q      <= S_IDLE;
          done_o       <= 1'b1;
          status_o     <= pmt_pkg::ST_NOT_FOUND;
          phys_frame_o <= '0;
          tlb_update_o <= pmt_pkg::TLB_NONE;
          unique case (cmd_q)
            pmt_pkg::CMD_MAP: begin
              if (dup_q) begin
                status_o <= pmt_pkg::ST_ALREADY;
              end else if (!empty_q) begin
                status_o <= pmt_pkg::ST_FULL;
              end else begin
                status_o     <= pmt_pkg::ST_DONE;
                tlb_update_o <= pmt_pkg::TLB_WRITE;
              end
            end
            pmt_pkg::CMD_LOOKUP: begin
              if (hit_q) begin
                status_o     <= pmt_pkg::ST_DONE;
                phys_frame_o <= hit_pf_q;
              end
            end
            pmt_pkg::CMD_REMOVE: begin
              if (hit_q) begin
                status_o     <= pmt_pkg::ST_DONE;
                tlb_update_o <= pmt_pkg::TLB_INVAL;
              end
            end
            default: begin
              // The undefined code changes nothing and reports not found.
            end
          endcase
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pmt_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the page mapping table.
module pmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [pmt_pkg::FrameW-1:0] phys_frame_o,
  input logic [1:0]  tlb_update_o
);

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  // The result word appears exactly when busy drops.
  a_done_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result is never shown while a command is still in work.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Only a successful command issues a TLB action.
  a_tlb_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (tlb_update_o != pmt_pkg::TLB_NONE)) |-> (status_o == pmt_pkg::ST_DONE))
    else $error("TLB action on a failed command");

  // A nonzero frame comes only from a successful lookup.
  a_frame_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (phys_frame_o != '0)) |->
      ((status_o == pmt_pkg::ST_DONE) && (tlb_update_o == pmt_pkg::TLB_NONE)))
    else $error("frame returned outside a lookup hit");

endmodule

bind page_mapping_table pmt_checker u_pmt_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pmt_pkg::*;

  localparam int unsigned SLOTS      = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  // Quiet cycles allowed before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 30 * (SLOTS + 2);
  localparam int unsigned MAX_REPORTS    = 10;
  // The command code that the block does not define.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam int unsigned VIRT_POOL = 12;
  localparam int unsigned PHYS_POOL = 6;

  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] frame;
    tlb_e              tlb;
  } table_reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        cmd_i;
  logic [31:0]       virt_addr_i;
  logic [31:0]       phys_addr_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [FrameW-1:0] phys_frame_o;
  logic [1:0]        tlb_update_o;

  // Shadow copy of the mapping table.
  bit                shadow_valid[SLOTS];
  logic [FrameW-1:0] shadow_vframe[SLOTS];
  logic [FrameW-1:0] shadow_pframe[SLOTS];

  table_reply_t      replies_due[$];
  table_reply_t      reply_due;
  int unsigned       fault_count;
  int unsigned       quiet_cycles;
  bit                hold_off_en;
  logic [FrameW-1:0] virt_pool[VIRT_POOL];
  logic [FrameW-1:0] phys_pool[PHYS_POOL];

  page_mapping_table #(
    .SLOTS     (SLOTS),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .virt_addr_i (virt_addr_i),
    .phys_addr_i (phys_addr_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .phys_frame_o(phys_frame_o),
    .tlb_update_o(tlb_update_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lowest-indexed valid slot holding this virtual frame, or -1.
  function automatic int first_virt_hit(logic [FrameW-1:0] vframe);
    for (int s = 0; s < SLOTS; s++) begin
      if (shadow_valid[s] && shadow_vframe[s] == vframe) begin
        return s;
      end
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the word it yields.
  function automatic table_reply_t apply_to_shadow_table(logic [1:0] cmd,
                                                         logic [31:0] virt_addr,
                                                         logic [31:0] phys_addr);
    table_reply_t      reply;
    logic [FrameW-1:0] vframe;
    logic [FrameW-1:0] pframe;
    int                free_slot;
    int                hit;
    bit                pair_present;
    vframe       = FrameW'(virt_addr >> PAGE_SHIFT);
    pframe       = FrameW'(phys_addr >> PAGE_SHIFT);
    reply.status = ST_NOT_FOUND;
    reply.frame  = '0;
    reply.tlb    = TLB_NONE;
    free_slot    = -1;
    pair_present = 1'b0;
    case (cmd)
      CMD_MAP: begin
        // The duplicate check wins over a full table; the highest free slot is used.
        for (int s = 0; s < SLOTS; s++) begin
          if (!shadow_valid[s]) begin
            free_slot = s;
          end else if (shadow_vframe[s] == vframe && shadow_pframe[s] == pframe) begin
            pair_present = 1'b1;
          end
        end
        if (pair_present) begin
          reply.status = ST_ALREADY;
        end else if (free_slot < 0) begin
          reply.status = ST_FULL;
        end else begin
          shadow_vframe[free_slot] = vframe;
          shadow_pframe[free_slot] = pframe;
          shadow_valid[free_slot]  = 1'b1;
          reply.status             = ST_DONE;
          reply.tlb                = TLB_WRITE;
        end
      end
      CMD_LOOKUP: begin
        hit = first_virt_hit(vframe);
        if (hit >= 0) begin
          reply.status = ST_DONE;
          reply.frame  = shadow_pframe[hit];
        end
      end
      CMD_REMOVE: begin
        hit = first_virt_hit(vframe);
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          reply.status      = ST_DONE;
          reply.tlb         = TLB_INVAL;
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Sends one command word and records the reply it must produce.
  task automatic issue_word(logic [1:0] cmd, logic [31:0] virt_addr, logic [31:0] phys_addr);
    int unsigned gap;
    gap = hold_off_en ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      // Let the block finish, then hold the next word back for a random gap.
      start = 1'b0;
      do @(posedge clk_i); while (busy);
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    cmd_i       = cmd;
    virt_addr_i = virt_addr;
    phys_addr_i = phys_addr;
    do @(posedge clk_i); while (busy);
    replies_due.push_back(apply_to_shadow_table(cmd, virt_addr, phys_addr));
  endtask

  // An address inside the given frame with a random page offset.
  function automatic logic [31:0] addr_in_frame(logic [FrameW-1:0] frame);
    return (32'(frame) << PAGE_SHIFT) | ($urandom() & ((32'd1 << PAGE_SHIFT) - 1));
  endfunction

  function automatic logic [31:0] pick_virt_addr();
    if ($urandom_range(0, 99) < 85) begin
      return addr_in_frame(virt_pool[$urandom_range(0, VIRT_POOL - 1)]);
    end
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_phys_addr();
    if ($urandom_range(0, 99) < 85) begin
      return addr_in_frame(phys_pool[$urandom_range(0, PHYS_POOL - 1)]);
    end
    return $urandom();
  endfunction

  // Commands on an empty table, including the undefined code.
  task automatic test_empty_table();
    issue_word(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_word(CMD_UNDEFINED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Map, duplicate, lookup priority and remove on the extreme frames.
  task automatic test_map_lookup_remove();
    issue_word(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_word(CMD_MAP, 32'hFFFF_F000, 32'hFFFF_F123);
    issue_word(CMD_LOOKUP, 32'hFFFF_F000, 32'h0000_0000);
    // Same virtual frame, new physical frame: lands in a lower slot.
    issue_word(CMD_MAP, 32'hFFFF_FFFF, 32'h0000_0FFF);
    issue_word(CMD_LOOKUP, 32'hFFFF_FABC, 32'hFFFF_FFFF);
    issue_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_word(CMD_LOOKUP, 32'hFFFF_F001, 32'h0000_0000);
    issue_word(CMD_MAP, 32'h0000_0000, 32'h8000_0000);
    issue_word(CMD_LOOKUP, 32'h0000_0FFF, 32'h0000_0000);
    issue_word(CMD_UNDEFINED, 32'h0000_0000, 32'h8000_0000);
    issue_word(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue_word(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    issue_word(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue_word(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_word(CMD_MAP, 32'h5555_5555, 32'hAAAA_AAAA);
    issue_word(CMD_LOOKUP, 32'h5555_5000, 32'h0000_0000);
    issue_word(CMD_REMOVE, 32'h5555_5AAA, 32'h0000_0000);
  endtask

  // Fills every slot, then overflows, and reuses a freed slot.
  task automatic test_fill_overflow();
    int unsigned used;
    logic [31:0] kept_virt;
    logic [31:0] kept_phys;
    kept_virt = $urandom();
    kept_phys = $urandom();
    issue_word(CMD_MAP, kept_virt, kept_phys);
    forever begin
      used = 0;
      foreach (shadow_valid[s]) used += shadow_valid[s];
      if (used >= SLOTS) break;
      issue_word(CMD_MAP, $urandom(), $urandom());
    end
    issue_word(CMD_MAP, $urandom(), $urandom());
    // A duplicate is still reported as such on a full table.
    issue_word(CMD_MAP, kept_virt, kept_phys);
    issue_word(CMD_LOOKUP, kept_virt, 32'h0000_0000);
    issue_word(CMD_REMOVE, kept_virt, 32'h0000_0000);
    issue_word(CMD_MAP, kept_virt, kept_phys);
    issue_word(CMD_MAP, $urandom(), $urandom());
  endtask

  // Rounds of random traffic over small frame pools, cycling through fill,
  // balanced and drain mixes so that hits, duplicates and a full table recur.
  task automatic test_random_traffic();
    int unsigned map_pct;
    int unsigned lookup_pct;
    int unsigned remove_pct;
    int unsigned pick;
    logic [1:0]  cmd;
    for (int round = 0; round < 12; round++) begin
      foreach (virt_pool[i]) virt_pool[i] = FrameW'($urandom());
      foreach (phys_pool[i]) phys_pool[i] = FrameW'($urandom());
      hold_off_en = (round % 4 != 3);
      case (round % 3)
        0: begin
          map_pct = 65; lookup_pct = 20; remove_pct = 12;
        end
        1: begin
          map_pct = 40; lookup_pct = 30; remove_pct = 27;
        end
        default: begin
          map_pct = 20; lookup_pct = 30; remove_pct = 47;
        end
      endcase
      repeat (155) begin
        pick = $urandom_range(0, 99);
        if (pick < map_pct) begin
          cmd = CMD_MAP;
        end else if (pick < map_pct + lookup_pct) begin
          cmd = CMD_LOOKUP;
        end else if (pick < map_pct + lookup_pct + remove_pct) begin
          cmd = CMD_REMOVE;
        end else begin
          cmd = CMD_UNDEFINED;
        end
        issue_word(cmd, pick_virt_addr(), pick_phys_addr());
      end
    end
  endtask

  // Drains the outstanding replies and leaves room for a stray one.
  task automatic finish_run();
    @(negedge clk_i);
    start = 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  // Checks every reply word against the oldest recorded one.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("%0t: reply word with none due: status %0d frame %h tlb %0d",
                   $realtime, status_o, phys_frame_o, tlb_update_o);
        end
      end else begin
        reply_due = replies_due.pop_front();
        if (status_o !== reply_due.status || phys_frame_o !== reply_due.frame ||
            tlb_update_o !== reply_due.tlb) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected status %0d frame %h tlb %0d, got %0d %h %0d",
                     $realtime, reply_due.status, reply_due.frame, reply_due.tlb,
                     status_o, phys_frame_o, tlb_update_o);
          end
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no word moves either way.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_MAP;
    virt_addr_i  = '0;
    phys_addr_i  = '0;
    fault_count  = 0;
    quiet_cycles = 0;
    hold_off_en  = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_map_lookup_remove();
    test_fill_overflow();
    test_random_traffic();
    finish_run();

    if (fault_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_frame_ram.sv
hw/rtl/page_mapping_table.sv
hw/rtl/pmt_checker.sv
test/tb_top.sv
